// ===== sv/ifv_pkg.sv =====
// Shared types, constants and a helper function of the IDX file header validator.
package ifv_pkg;

   // Width of the size arithmetic; the size limit is 2^SIZE_WIDTH - 1
   localparam int unsigned SIZE_WIDTH = 64;
   localparam logic [63:0] SIZE_LIMIT = {64{1'b1}} >> (64 - SIZE_WIDTH);

   // Fixed header part: two padding bytes, type code, dimension count
   localparam int unsigned HDR_BASE = 4;
   localparam int unsigned HDR_W    = 11;

   // Command queue between front and back
   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Status codes
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_TRUNCATED     = 3'd1;
   localparam logic [2:0] STATUS_BAD_PADDING   = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN_TYPE  = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW      = 3'd4;
   localparam logic [2:0] STATUS_OVERALLOCATED = 3'd5;

   // Element type codes
   localparam logic [7:0] TYPE_U8  = 8'h08;
   localparam logic [7:0] TYPE_S8  = 8'h09;
   localparam logic [7:0] TYPE_S16 = 8'h0B;
   localparam logic [7:0] TYPE_S32 = 8'h0C;
   localparam logic [7:0] TYPE_F32 = 8'h0D;
   localparam logic [7:0] TYPE_F64 = 8'h0E;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  type_code;
      logic [7:0]  dim_count;
      logic [63:0] expected_size;
   } rsp_type;

   // One command per byte that needs back-end work
   typedef struct packed {
      logic             do_width;     // load element size into data size
      logic             do_mul;       // multiply data size by a bound
      logic             do_fin;       // file ends with this byte
      logic             need_size;    // header checks passed, size checks decide
      logic [2:0]       early_status; // status from header checks
      logic [31:0]      operand;      // bound or element size
      logic [HDR_W-1:0] hdr;          // header length in bytes
      logic [63:0]      count;        // byte count after this byte
      logic [7:0]       type_code;
      logic [7:0]       dim_count;
   } cmd_type;

   // Element size for a type code, zero for an unknown code
   function automatic logic [3:0] elem_width(input logic [7:0] code);
      logic [3:0] w;
      case (code)
         TYPE_U8, TYPE_S8:   w = 4'd1;
         TYPE_S16:           w = 4'd2;
         TYPE_S32, TYPE_F32: w = 4'd4;
         TYPE_F64:           w = 4'd8;
         default:            w = 4'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== sv/ifv_front.sv =====
// Front end: tracks byte position, parses the header and issues commands.
module ifv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ifv_pkg::req_type req_data,
   output logic             cmd_push,
   output ifv_pkg::cmd_type cmd_data,
   input  logic             cmd_full
);
   import ifv_pkg::*;

   logic [63:0]      byte_count_ff, byte_count_in;
   logic             pad_ff, pad_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       dim_ff, dim_in;
   logic [31:0]      shift_ff, shift_in;

   logic             accept;
   logic [63:0]      pos;
   logic [63:0]      count_nx;
   logic             pad_nx;
   logic [7:0]       type_nx;
   logic [7:0]       dim_nx;
   logic [HDR_W-1:0] hdr_cur;
   logic [HDR_W-1:0] hdr_nx;
   logic             in_bounds;
   logic             bound_done;
   logic [31:0]      shift_nx;
   logic [3:0]       width_nx;
   logic [2:0]       early;
   logic             need_size;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;
   assign pos    = byte_count_ff;

   // Parse this byte against the current position
   always_comb begin
      hdr_cur    = HDR_W'(HDR_BASE) + {1'b0, dim_ff, 2'b00};
      pad_nx     = pad_ff | ((pos < 64'd2) && (req_data.file_byte != 8'd0));
      type_nx    = (pos == 64'd2) ? req_data.file_byte : type_ff;
      dim_nx     = (pos == 64'd3) ? req_data.file_byte : dim_ff;
      hdr_nx     = HDR_W'(HDR_BASE) + {1'b0, dim_nx, 2'b00};
      in_bounds  = (pos >= 64'(HDR_BASE)) && (pos < 64'(hdr_cur));
      bound_done = in_bounds && (pos[1:0] == 2'b11);
      shift_nx   = in_bounds ? {shift_ff[23:0], req_data.file_byte} : shift_ff;
      count_nx   = (&pos) ? pos : pos + 64'd1;
      width_nx   = elem_width(type_nx);
   end

   // Header checks in priority order
   always_comb begin
      need_size = 1'b0;
      if (count_nx < 64'(HDR_BASE)) begin
         early = STATUS_TRUNCATED;
      end else if (pad_nx) begin
         early = STATUS_BAD_PADDING;
      end else if (count_nx < 64'(hdr_nx)) begin
         early = STATUS_TRUNCATED;
      end else if (width_nx == 4'd0) begin
         early = STATUS_UNKNOWN_TYPE;
      end else begin
         early     = STATUS_OK;
         need_size = 1'b1;
      end
   end

   // Build the command for the back end
   always_comb begin
      cmd_data.do_width     = (pos == 64'd2);
      cmd_data.do_mul       = bound_done;
      cmd_data.do_fin       = req_data.is_last;
      cmd_data.need_size    = need_size;
      cmd_data.early_status = early;
      if (pos == 64'd2) begin
         cmd_data.operand = (width_nx == 4'd0) ? 32'd1 : 32'(width_nx);
      end else begin
         cmd_data.operand = shift_nx;
      end
      cmd_data.hdr       = hdr_nx;
      cmd_data.count     = count_nx;
      cmd_data.type_code = type_nx;
      cmd_data.dim_count = dim_nx;
      cmd_push = accept && ((pos == 64'd2) || bound_done || req_data.is_last);
   end

   // Advance the parse state, clear it at the end of a file
   always_comb begin
      byte_count_in = byte_count_ff;
      pad_in        = pad_ff;
      type_in       = type_ff;
      dim_in        = dim_ff;
      shift_in      = shift_ff;
      if (accept) begin
         if (req_data.is_last) begin
            byte_count_in = 64'd0;
            pad_in        = 1'b0;
            type_in       = 8'd0;
            dim_in        = 8'd0;
            shift_in      = 32'd0;
         end else begin
            byte_count_in = count_nx;
            pad_in        = pad_nx;
            type_in       = type_nx;
            dim_in        = dim_nx;
            shift_in      = shift_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 64'd0;
         pad_ff        <= 1'b0;
         type_ff       <= 8'd0;
         dim_ff        <= 8'd0;
         shift_ff      <= 32'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         pad_ff        <= pad_in;
         type_ff       <= type_in;
         dim_ff        <= dim_in;
         shift_ff      <= shift_in;
      end
   end

endmodule

// ===== sv/ifv_cmd_fifo.sv =====
// Small command queue that decouples the front end from the back end.
module ifv_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ifv_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output ifv_pkg::cmd_type head,
   output logic             empty
);
   import ifv_pkg::*;

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ifv_back.sv =====
// Back end: multiplies the data size by each bound and forms the file status.
module ifv_back (
   input  logic             clock,
   input  logic             reset,
   input  ifv_pkg::cmd_type cmd_head,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output ifv_pkg::rsp_type rsp_data
);
   import ifv_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_LO   = 5'b00010,
      B_HI   = 5'b00100,
      B_CHK  = 5'b01000,
      B_FIN  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [63:0]    data_ff, data_in;
   logic           ovf_ff, ovf_in;
   logic [63:0]    lo_ff, lo_in;
   logic [63:0]    hi_ff, hi_in;
   logic [63:0]    lim_ff, lim_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           can_out;
   logic           emit;
   logic           head_mul;
   logic [63:0]    lo_prod;
   logic [63:0]    hi_prod;
   logic [63:0]    mid;
   logic [63:0]    prod;
   logic           over;
   cmd_type        fin_cmd;
   logic [63:0]    expected;
   rsp_type        fin_rsp;

   assign can_out  = !rsp_valid_ff || pop;
   assign head_mul = cmd_head.do_mul && !ovf_ff;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Partial products of bound times data size
   assign lo_prod = cur_ff.operand * data_ff[31:0];
   assign hi_prod = cur_ff.operand * data_ff[63:32];

   // Combine partial products and test against the limit
   always_comb begin
      mid  = hi_ff + {32'd0, lo_ff[63:32]};
      prod = {mid[31:0], lo_ff[31:0]};
      over = (mid[63:32] != 32'd0) || (prod > lim_ff);
   end

   // Form the status of a finished file
   always_comb begin
      fin_cmd  = (state_ff == B_FIN) ? cur_ff : cmd_head;
      expected = 64'(fin_cmd.hdr) + data_ff;
      fin_rsp.type_code     = fin_cmd.type_code;
      fin_rsp.dim_count     = fin_cmd.dim_count;
      fin_rsp.expected_size = 64'd0;
      if (!fin_cmd.need_size) begin
         fin_rsp.status = fin_cmd.early_status;
      end else if (ovf_ff) begin
         fin_rsp.status = STATUS_OVERFLOW;
      end else begin
         fin_rsp.expected_size = expected;
         if (expected > fin_cmd.count) begin
            fin_rsp.status = STATUS_TRUNCATED;
         end else if (expected < fin_cmd.count) begin
            fin_rsp.status = STATUS_OVERALLOCATED;
         end else begin
            fin_rsp.status = STATUS_OK;
         end
      end
   end

   // Sequence commands through the partial-product multipliers
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      data_in  = data_ff;
      ovf_in   = ovf_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      lim_in   = lim_ff;
      emit     = 1'b0;
      cmd_pop  = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               if (head_mul) begin
                  cmd_pop  = 1'b1;
                  cur_in   = cmd_head;
                  state_in = B_LO;
               end else if (!cmd_head.do_fin || can_out) begin
                  cmd_pop = 1'b1;
                  if (cmd_head.do_width) begin
                     data_in = 64'(cmd_head.operand);
                  end
                  if (cmd_head.do_fin) begin
                     emit    = 1'b1;
                     data_in = 64'd1;
                     ovf_in  = 1'b0;
                  end
               end
            end
         end
         B_LO: begin
            lo_in    = lo_prod;
            lim_in   = SIZE_LIMIT - 64'(cur_ff.hdr);
            state_in = B_HI;
         end
         B_HI: begin
            hi_in    = hi_prod;
            state_in = B_CHK;
         end
         B_CHK: begin
            if (over) begin
               ovf_in = 1'b1;
            end else begin
               data_in = prod;
            end
            state_in = cur_ff.do_fin ? B_FIN : B_IDLE;
         end
         B_FIN: begin
            if (can_out) begin
               emit     = 1'b1;
               data_in  = 64'd1;
               ovf_in   = 1'b0;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_in       = emit ? fin_rsp : rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         data_ff      <= 64'd1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_ff      <= data_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      lim_ff <= lim_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/idx_file_validator_top.sv =====
// Top level of the IDX file header validator: front end, command queue, back end.
// Takes one file byte per cycle while the command queue is not full; each file ends
// with a byte marked last and gets exactly one status. Header bytes are checked in
// the front end as they arrive. Every completed 32-bit bound passes through the back
// end on its two 32x32 partial-product multipliers in steps (issue, low partial
// product, high partial product and a limit check), plus a finish step when the bound
// ends the file; other commands are handled at issue. A four-entry command queue
// absorbs this, and a status is registered after its last byte and held until pop takes it.
module idx_file_validator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ifv_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ifv_pkg::rsp_type rsp_data
);
   import ifv_pkg::*;

   cmd_type cmd_in_data;
   cmd_type cmd_head;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;

   // Parse bytes and issue commands
   ifv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   // Buffer commands between the two halves
   ifv_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   // Compute sizes and deliver the status
   ifv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
